// File: rtl/crcfr_pkg.sv
// Package for the CRC-checked frame receiver: frame constants, the result
// word type and the CRC-8 byte update. No dependencies.
`timescale 1ns / 1ps

package crcfr_pkg;

    localparam int unsigned FRAME_LEN   = 16;
    localparam int unsigned CRC_SPAN    = 15;
    localparam int unsigned POS_W       = 4;
    localparam logic [7:0]  CRC_POLY    = 8'h07;
    localparam logic [7:0]  ADDR_RESET  = 8'd178;
    localparam logic [POS_W-1:0] POS_HUNT  = 4'd0;
    localparam logic [POS_W-1:0] POS_CHECK = 4'(CRC_SPAN);

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [7:0]  frame_flags;
        logic [7:0]  command;
        logic [7:0]  param_address;
        logic [63:0] payload_low;
        logic [23:0] payload_high;
    } result_t;

    // One byte through CRC-8, polynomial 0x07, MSB first.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/crc_checked_frame_receiver_core.sv
// Top level of the CRC-checked frame receiver: input register, address
// register, frame tracking and result register. Depends on crcfr_pkg,
// crcfr_frame_ctrl and crcfr_out_reg.
`timescale 1ns / 1ps

// Channel   | Direction | Ports                          | Word
// ----------+-----------+--------------------------------+---------------------------
// input     | in        | s_valid, s_ready, s_rx_byte    | one received byte
// result    | out       | m_valid, m_ready, m_*          | fields of one good frame
// config    | in        | cfg_valid, cfg_ready, cfg_device_address | device address
//
// One byte is accepted per cycle unless the input stalls. A good frame
// passes the input register and the frame check into the result register.
// The frame check and the CRC update take one byte per cycle while the
// result register is free. Synchronous active-low reset clears position,
// CRC, valid flags and sets the address to 178. A stalled result stalls
// the input only once the input register is also full.

module crc_checked_frame_receiver_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_flags,
    output logic [7:0]  m_command,
    output logic [7:0]  m_param_address,
    output logic [63:0] m_payload_low,
    output logic [23:0] m_payload_high,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_device_address
);

    logic               in_valid_reg, in_valid_next;
    logic [7:0]         in_byte_reg;
    logic [7:0]         addr_reg;
    logic               advance;
    logic               out_free;
    logic               res_valid;
    crcfr_pkg::result_t res;
    crcfr_pkg::result_t res_out;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && out_free;
    assign s_ready       = !in_valid_reg || advance;
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            addr_reg     <= crcfr_pkg::ADDR_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_valid && cfg_ready) begin
                addr_reg <= cfg_device_address;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    crcfr_frame_ctrl u_frame_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .byte_valid     (advance),
        .rx_byte        (in_byte_reg),
        .device_address (addr_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    crcfr_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_valid),
        .res      (res),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .out_free (out_free),
        .res_out  (res_out)
    );

    assign m_frame_flags   = res_out.frame_flags;
    assign m_command       = res_out.command;
    assign m_param_address = res_out.param_address;
    assign m_payload_low   = res_out.payload_low;
    assign m_payload_high  = res_out.payload_high;

endmodule

// File: rtl/crcfr_frame_ctrl.sv
// Frame tracking: byte position, running CRC and the shift line that holds
// frame bytes 0 to 14. Depends on crcfr_pkg.
`timescale 1ns / 1ps

module crcfr_frame_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_valid,
    input  logic [7:0]           rx_byte,
    input  logic [7:0]           device_address,
    output logic                 res_valid,
    output crcfr_pkg::result_t   res
);

    logic [crcfr_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0]                  crc_reg, crc_next;
    // Newest byte sits at index 0; after 15 bytes frame byte k is at 14-k.
    crcfr_pkg::byte_t            store_reg [crcfr_pkg::CRC_SPAN];
    logic                        shift_en;

    always_comb begin
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        shift_en  = 1'b0;
        res_valid = 1'b0;
        if (byte_valid) begin
            if (pos_reg == crcfr_pkg::POS_HUNT) begin
                if (rx_byte == device_address) begin
                    shift_en = 1'b1;
                    crc_next = crcfr_pkg::crc8_feed(8'd0, rx_byte);
                    pos_next = pos_reg + 4'd1;
                end
            end else if (pos_reg != crcfr_pkg::POS_CHECK) begin
                shift_en = 1'b1;
                crc_next = crcfr_pkg::crc8_feed(crc_reg, rx_byte);
                pos_next = pos_reg + 4'd1;
            end else begin
                // The address is checked again in case it changed mid-frame.
                res_valid = (crc_reg == rx_byte) && (store_reg[14] == device_address);
                crc_next  = 8'd0;
                pos_next  = crcfr_pkg::POS_HUNT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= crcfr_pkg::POS_HUNT;
            crc_reg <= 8'd0;
        end else begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            store_reg[0] <= rx_byte;
            for (int i = 1; i < crcfr_pkg::CRC_SPAN; i++) begin
                store_reg[i] <= store_reg[i-1];
            end
        end
    end

    always_comb begin
        res.frame_flags   = store_reg[13];
        res.command       = store_reg[12];
        res.param_address = store_reg[11];
        res.payload_low   = {store_reg[10], store_reg[9], store_reg[8], store_reg[7],
                             store_reg[6], store_reg[5], store_reg[4], store_reg[3]};
        res.payload_high  = {store_reg[2], store_reg[1], store_reg[0]};
    end

endmodule

// File: rtl/crcfr_out_reg.sv
// Result register: holds one accepted frame until the result channel takes
// it. Depends on crcfr_pkg.
`timescale 1ns / 1ps

module crcfr_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  crcfr_pkg::result_t   res,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic                 out_free,
    output crcfr_pkg::result_t   res_out
);

    logic               valid_reg, valid_next;
    crcfr_pkg::result_t res_reg;

    assign out_free   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);
    assign m_valid    = valid_reg;
    assign res_out    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

// File: rtl/crcfr_checker.sv
// Port-level checks for the frame receiver and the bind that attaches them
// to crc_checked_frame_receiver_core. No package dependencies.
`timescale 1ns / 1ps

module crcfr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_frame_flags,
    input logic [63:0] m_payload_low
);

    // A waiting result keeps its word.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_flags) && $stable(m_payload_low))
        else $error("result word changed while stalled");

    // Reset empties the result register.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // With the result register empty the input side never stalls.
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // A new result must follow a byte accepted on the input.
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result appeared without an accepted byte");

endmodule

bind crc_checked_frame_receiver_core crcfr_checker u_crcfr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_frame_flags (m_frame_flags),
    .m_payload_low (m_payload_low)
);

// File: dv/testbench.sv
// Self-checking testbench for crc_checked_frame_receiver_core: streams framed
// bytes with random gaps and stalls and checks every good frame that comes out.
// Depends on crcfr_pkg and the receiver RTL.
`timescale 1ns / 1ps

module testbench;

    import crcfr_pkg::*;

    localparam int PHASES        = 11;
    localparam int FRAMES        = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;

    // Tracks the receiver state byte by byte and keeps the frames that
    // should come out, oldest first.
    class frame_ledger;
        byte_t      own_addr;
        logic [3:0] pos;
        byte_t      crc;
        byte_t      store [CRC_SPAN];
        result_t    pending_q [$];
        int         errors;

        function new();
            own_addr = ADDR_RESET;
            pos      = POS_HUNT;
            crc      = 8'h00;
            errors   = 0;
        endfunction

        static function byte_t crc_next(input byte_t c, input byte_t b);
            byte_t r;
            r = c ^ b;
            repeat (8) begin
                r = r[7] ? ((r << 1) ^ 8'h07) : (r << 1);
            end
            return r;
        endfunction

        function void set_address(input byte_t a);
            own_addr = a;
        endfunction

        function void note_byte(input byte_t b);
            result_t exp;
            if (pos == POS_HUNT) begin
                if (b == own_addr) begin
                    store[0] = b;
                    crc      = crc_next(8'h00, b);
                    pos      = 4'd1;
                end
            end else if (pos != POS_CHECK) begin
                store[pos] = b;
                crc        = crc_next(crc, b);
                pos        = pos + 4'd1;
            end else begin
                // The stored address byte is compared with the address in
                // force now, so a change in mid-frame drops the frame.
                if (b == crc && store[0] == own_addr) begin
                    exp.frame_flags   = store[1];
                    exp.command       = store[2];
                    exp.param_address = store[3];
                    exp.payload_low   = {store[4], store[5], store[6], store[7],
                                         store[8], store[9], store[10], store[11]};
                    exp.payload_high  = {store[12], store[13], store[14]};
                    pending_q.push_back(exp);
                end
                pos = POS_HUNT;
                crc = 8'h00;
            end
        endfunction

        task report(input string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(input result_t got);
            result_t exp;
            if (pending_q.size() == 0) begin
                report($sformatf("result word with no frame pending: %h", got));
            end else begin
                exp = pending_q.pop_front();
                if (got.frame_flags !== exp.frame_flags)
                    report($sformatf("frame_flags %h, want %h",
                                     got.frame_flags, exp.frame_flags));
                if (got.command !== exp.command)
                    report($sformatf("command %h, want %h", got.command, exp.command));
                if (got.param_address !== exp.param_address)
                    report($sformatf("param_address %h, want %h",
                                     got.param_address, exp.param_address));
                if (got.payload_low !== exp.payload_low)
                    report($sformatf("payload_low %h, want %h",
                                     got.payload_low, exp.payload_low));
                if (got.payload_high !== exp.payload_high)
                    report($sformatf("payload_high %h, want %h",
                                     got.payload_high, exp.payload_high));
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_frame_flags;
    logic [7:0]  m_command;
    logic [7:0]  m_param_address;
    logic [63:0] m_payload_low;
    logic [23:0] m_payload_high;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_device_address;

    frame_ledger ledger = new();
    bit          quiet = 1'b0;
    int          stall_budget = 0;

    crc_checked_frame_receiver_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_rx_byte          (s_rx_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_frame_flags      (m_frame_flags),
        .m_command          (m_command),
        .m_param_address    (m_param_address),
        .m_payload_low      (m_payload_low),
        .m_payload_high     (m_payload_high),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_device_address (cfg_device_address)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Each task below is entered just after a rising edge; push_byte and
    // write_addr return just after the edge at which their word was taken.
    task automatic push_byte(input byte_t b);
        while (!quiet && $urandom_range(99) < 12) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        ledger.note_byte(b);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (ledger.pending_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_addr(input byte_t a);
        settle();
        cfg_valid          <= 1'b1;
        cfg_device_address <= a;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ledger.set_address(a);
    endtask

    // fill < 0 gives random content and sometimes a bad check byte or a cut
    // frame; otherwise the body alternates fill and its complement. A nonzero
    // split writes next_addr before that byte of the frame.
    task automatic send_frame(input byte_t addr, input int fill, input int split,
                              input byte_t next_addr);
        byte_t fb [FRAME_LEN];
        byte_t c;
        int    len;
        fb[0] = addr;
        for (int i = 1; i < CRC_SPAN; i++) begin
            if (fill < 0)
                fb[i] = byte_t'($urandom_range(255));
            else
                fb[i] = (i % 2) ? byte_t'(fill) : ~byte_t'(fill);
        end
        c = 8'h00;
        for (int i = 0; i < CRC_SPAN; i++) c = frame_ledger::crc_next(c, fb[i]);
        fb[CRC_SPAN] = c;
        len = FRAME_LEN;
        if (fill < 0) begin
            if ($urandom_range(99) < 15)
                fb[CRC_SPAN] = c ^ byte_t'($urandom_range(1, 255));
            if (split == 0 && $urandom_range(99) < 5)
                len = $urandom_range(1, FRAME_LEN - 1);
        end
        for (int i = 0; i < len; i++) begin
            if (split > 0 && i == split) write_addr(next_addr);
            push_byte(fb[i]);
        end
    endtask

    initial begin : result_sink
        result_t got;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got = {m_frame_flags, m_command, m_param_address,
                       m_payload_low, m_payload_high};
                ledger.check_result(got);
            end
            if (stall_budget > 0) begin
                stall_budget--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= 12);
            end
        end
    end

    initial begin : stimulus
        byte_t phase_addr [PHASES];
        byte_t nb;
        bit    carried;
        int    split;

        s_valid            = 1'b0;
        s_rx_byte          = 8'h00;
        cfg_valid          = 1'b0;
        cfg_device_address = 8'h00;
        aresetn            = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extreme bytes that do not open a frame, then a good
        // frame at the reset address with alternating all-zero and all-one bytes.
        push_byte(8'h00);
        push_byte(8'hFF);
        send_frame(ADDR_RESET, 8'h00, 0, 8'h00);

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0)
                phase_addr[p] = ADDR_RESET;
            else if (p == 1)
                phase_addr[p] = 8'h00;
            else if (p == 2)
                phase_addr[p] = 8'hFF;
            else if (p == PHASES - 1)
                phase_addr[p] = ADDR_RESET;
            else
                phase_addr[p] = byte_t'($urandom_range(255));
        end

        carried = 1'b0;
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0 && !carried) write_addr(phase_addr[p]);
            carried = 1'b0;
            quiet   = (p == 4);
            // Long hold on the result side while the input keeps coming.
            if (p == 6) stall_budget = HOLD_CYCLES;
            for (int f = 0; f < FRAMES; f++) begin
                repeat ($urandom_range(0, 3)) begin
                    do nb = byte_t'($urandom_range(255)); while (nb == phase_addr[p]);
                    push_byte(nb);
                end
                split = 0;
                if (f == FRAMES - 1 && p < PHASES - 1 && p % 3 == 2) begin
                    split   = $urandom_range(1, CRC_SPAN - 1);
                    carried = 1'b1;
                end
                send_frame(phase_addr[p], -1, split,
                           (p < PHASES - 1) ? phase_addr[p + 1] : ADDR_RESET);
            end
        end
        quiet = 1'b0;

        settle();
        if (ledger.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: crc_checked_frame_receiver_core.f
rtl/crcfr_pkg.sv
rtl/crcfr_frame_ctrl.sv
rtl/crcfr_out_reg.sv
rtl/crc_checked_frame_receiver_core.sv
rtl/crcfr_checker.sv
dv/testbench.sv
